### rtl/ohr_pkg.sv
// Shared types and constants for the overwriting history ring.
package ohr_pkg;

  // Fixed payload widths of the request and result channels
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 5;

  // Request operation codes
  typedef enum logic [MODE_W-1:0] {
    MODE_PUT     = 2'd0,
    MODE_RETRACT = 2'd1,
    MODE_CLEAR   = 2'd2,
    MODE_DUMP    = 2'd3
  } ohr_mode_t;

  // Sequencer states: idle, memory read issued, result load
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_READ = 2'd1,
    S_EMIT = 2'd2
  } ohr_state_t;

endpackage

### rtl/ohr_req_if.sv
// Request channel: operation code and entry data with valid/ready.
interface ohr_req_if
  import ohr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [DATA_W-1:0] data;

  modport source (output valid, mode, data, input ready);
  modport sink   (input valid, mode, data, output ready);
endinterface

### rtl/ohr_res_if.sv
// Result channel: newest or walked entry, oldest entry, count and flags.
interface ohr_res_if
  import ohr_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [DATA_W-1:0]  value;
  logic [DATA_W-1:0]  oldest;
  logic [COUNT_W-1:0] count;
  logic               empty_res;
  logic               last;

  modport source (output valid, value, oldest, count, empty_res, last, input ready);
  modport sink   (input valid, value, oldest, count, empty_res, last, output ready);
endinterface

### rtl/overwriting_history_ring.sv
// Top level: ring store of the last DEPTH entries, overwriting the oldest.
//
//   channel  dir  handshake    payload
//   req      in   valid/ready  mode, data
//   res      out  valid/ready  value, oldest, count, empty_res, last
//
// Each result passes through a read of the entry memory (two read ports,
// registered data), then a load of the output register. A put, retract
// or clear gives one result; a new request is taken only when the
// sequencer is back in idle, so requests do not overlap. A dump of n
// entries streams them newest first, one per result. Reset clears the fill
// position and the full flag; the entry memory is not cleared. A stalled
// result holds the sequencer; a new request is taken while the last result
// still waits.
module overwriting_history_ring
  import ohr_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  ohr_req_if.sink   req,
  ohr_res_if.source res
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  ohr_state_t     state, state_next;
  logic [CW-1:0]  fill_pos, fill_pos_next;
  logic           full, full_next;
  logic [PW-1:0]  walk_idx;
  logic [CW-1:0]  remain;
  logic [CW-1:0]  held, held_next;
  logic [PW-1:0]  wr_addr;
  logic [PW-1:0]  old_addr;
  logic [WIDTH-1:0] data_w;
  logic           req_fire;
  logic           out_free;
  ohr_mode_t      req_mode;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_val;
  logic [WIDTH-1:0] rd_old;

  logic               res_valid;
  logic [DATA_W-1:0]  res_value;
  logic [DATA_W-1:0]  res_oldest;
  logic [COUNT_W-1:0] res_count;
  logic               res_empty;
  logic               res_last;

  assign req_mode = ohr_mode_t'(req.mode);
  assign req_fire = req.valid && req.ready;
  assign out_free = !res_valid || res.ready;
  assign data_w   = WIDTH'(req.data);

  // Put address: wrap to slot 0 when empty or at the end
  assign wr_addr = ((fill_pos == '0) || (fill_pos >= CW'(DEPTH))) ? '0 : fill_pos[PW-1:0];

  // Oldest slot: slot 0 until full, then the fill position
  assign old_addr = (!full || (fill_pos >= CW'(DEPTH))) ? '0 : fill_pos[PW-1:0];

  // Held counts for the current and the updated state
  assign held      = (fill_pos == '0) ? '0 : (full ? CW'(DEPTH) : fill_pos);
  assign held_next = (fill_pos_next == '0) ? '0 : (full_next ? CW'(DEPTH) : fill_pos_next);

  // Compute the fill state after the request
  always_comb begin
    fill_pos_next = fill_pos;
    full_next     = full;
    case (req_mode)
      MODE_PUT: begin
        if (fill_pos == '0) begin
          fill_pos_next = CW'(1);
          full_next     = 1'b0;
        end else if (fill_pos >= CW'(DEPTH)) begin
          fill_pos_next = CW'(1);
          full_next     = 1'b1;
        end else begin
          fill_pos_next = fill_pos + CW'(1);
        end
      end
      MODE_RETRACT: begin
        if (fill_pos != '0) begin
          fill_pos_next = fill_pos - CW'(1);
          if (fill_pos == CW'(1)) begin
            full_next = 1'b0;
          end
        end
      end
      MODE_CLEAR: begin
        fill_pos_next = '0;
        full_next     = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Sequencer next state and ready
  always_comb begin
    state_next = state;
    req.ready  = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (req_fire) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          state_next = (remain <= CW'(1)) ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state, fill position and walk counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      fill_pos <= '0;
      full     <= 1'b0;
      walk_idx <= '0;
      remain   <= '0;
    end else begin
      state <= state_next;
      if (req_fire) begin
        fill_pos <= fill_pos_next;
        full     <= full_next;
        walk_idx <= (fill_pos_next == '0) ? '0 : PW'(fill_pos_next - CW'(1));
        if (req_mode == MODE_DUMP && held_next != '0) begin
          remain <= held_next;
        end else begin
          remain <= CW'(1);
        end
      end else if (state == S_EMIT && out_free) begin
        walk_idx <= (walk_idx == '0) ? PW'(DEPTH - 1) : walk_idx - PW'(1);
        remain   <= remain - CW'(1);
      end
    end
  end

  // Write a put entry into the ring memory
  always_ff @(posedge clk) begin
    if (req_fire && req_mode == MODE_PUT) begin
      mem[wr_addr] <= data_w;
    end
  end

  // Read the walked entry and the oldest entry
  always_ff @(posedge clk) begin
    rd_val <= mem[walk_idx];
    rd_old <= mem[old_addr];
  end

  // Load the output register; drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == S_EMIT && out_free) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      res_last <= (remain <= CW'(1));
      if (held == '0) begin
        res_value  <= '0;
        res_oldest <= '0;
        res_count  <= '0;
        res_empty  <= 1'b1;
      end else begin
        res_value  <= DATA_W'(rd_val);
        res_oldest <= DATA_W'(rd_old);
        res_count  <= COUNT_W'(held);
        res_empty  <= 1'b0;
      end
    end
  end

  assign res.valid     = res_valid;
  assign res.value     = res_value;
  assign res.oldest    = res_oldest;
  assign res.count     = res_count;
  assign res.empty_res = res_empty;
  assign res.last      = res_last;

endmodule
